FILE: src/sct_pkg.sv
package sct_pkg;

  // Field widths
  localparam int CharW  = 8;
  localparam int KindW  = 3;
  localparam int ModeW  = 3;

  // Most events one input byte can cause
  localparam int MaxEvents = 4;
  localparam int IdxW      = $clog2(MaxEvents);
  localparam int CntW      = $clog2(MaxEvents + 1);

  // Lexer modes
  localparam logic [ModeW-1:0] ModeIdle  = 3'd0;
  localparam logic [ModeW-1:0] ModeWord  = 3'd1;
  localparam logic [ModeW-1:0] ModeWesc  = 3'd2;
  localparam logic [ModeW-1:0] ModeSq    = 3'd3;
  localparam logic [ModeW-1:0] ModeDq    = 3'd4;
  localparam logic [ModeW-1:0] ModeDqesc = 3'd5;
  localparam logic [ModeW-1:0] ModeGt    = 3'd6;

  // Event kinds
  localparam logic [KindW-1:0] EvChar = 3'd0;
  localparam logic [KindW-1:0] EvWend = 3'd1;
  localparam logic [KindW-1:0] EvPipe = 3'd2;
  localparam logic [KindW-1:0] EvRout = 3'd3;
  localparam logic [KindW-1:0] EvRapp = 3'd4;
  localparam logic [KindW-1:0] EvRin  = 3'd5;
  localparam logic [KindW-1:0] EvEnd  = 3'd6;
  localparam logic [KindW-1:0] EvUncl = 3'd7;

  // Special bytes
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharHtab  = 8'h09;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharDq    = 8'h22;
  localparam logic [CharW-1:0] CharSq    = 8'h27;
  localparam logic [CharW-1:0] CharLt    = 8'h3C;
  localparam logic [CharW-1:0] CharGt    = 8'h3E;
  localparam logic [CharW-1:0] CharBsl   = 8'h5C;
  localparam logic [CharW-1:0] CharPipe  = 8'h7C;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] chr;
  } ev_t;

  typedef struct packed {
    ev_t [MaxEvents-1:0] ev;
    logic [CntW-1:0]     count;
  } ev_list_t;

  typedef struct packed {
    ev_list_t         lst;
    logic [ModeW-1:0] mode;
  } dec_t;

endpackage

FILE: src/sct_decode.sv
module sct_decode (
  input  logic [sct_pkg::ModeW-1:0] mode,
  input  logic [sct_pkg::CharW-1:0] chr,
  output sct_pkg::dec_t             dec
);
  import sct_pkg::*;

  // Append one event to the list
  function automatic ev_list_t push(ev_list_t l, logic [KindW-1:0] k, logic [CharW-1:0] c);
    ev_list_t r;
    r = l;
    if (r.count < CntW'(MaxEvents)) begin
      r.ev[r.count[IdxW-1:0]].kind = k;
      r.ev[r.count[IdxW-1:0]].chr  = (k == EvChar) ? c : CharNul;
      r.count = r.count + CntW'(1);
    end
    return r;
  endfunction

  function automatic logic is_delim(logic [CharW-1:0] c);
    return (c == CharNul) || (c == CharSpace) || ((c >= CharHtab) && (c <= CharCr)) ||
           (c == CharPipe) || (c == CharGt) || (c == CharLt);
  endfunction

  // Byte seen between tokens or inside an unquoted word
  function automatic dec_t plain_byte(dec_t d, logic [CharW-1:0] c, logic in_word);
    dec_t r;
    r = d;
    if (is_delim(c)) begin
      if (in_word) r.lst = push(r.lst, EvWend, CharNul);
      r.mode = ModeIdle;
      if (c == CharNul) r.lst = push(r.lst, EvEnd, CharNul);
      else if (c == CharPipe) r.lst = push(r.lst, EvPipe, CharNul);
      else if (c == CharLt) r.lst = push(r.lst, EvRin, CharNul);
      else if (c == CharGt) r.mode = ModeGt;
    end else if (c == CharSq) begin
      r.mode = ModeSq;
    end else if (c == CharDq) begin
      r.mode = ModeDq;
    end else if (c == CharBsl) begin
      r.mode = ModeWesc;
    end else begin
      r.lst  = push(r.lst, EvChar, c);
      r.mode = ModeWord;
    end
    return r;
  endfunction

  // Unclosed quote at line end
  function automatic dec_t open_quote_end(dec_t d);
    dec_t r;
    r = d;
    r.lst  = push(r.lst, EvUncl, CharNul);
    r.lst  = push(r.lst, EvWend, CharNul);
    r.lst  = push(r.lst, EvEnd, CharNul);
    r.mode = ModeIdle;
    return r;
  endfunction

  // Decode one byte against the current mode
  always_comb begin
    dec_t d;
    d = '0;
    d.mode = mode;
    case (mode)
      ModeWord: begin
        d = plain_byte(d, chr, 1'b1);
      end
      ModeWesc: begin
        if (chr == CharNul) begin
          d.lst  = push(d.lst, EvChar, CharBsl);
          d.lst  = push(d.lst, EvWend, CharNul);
          d.lst  = push(d.lst, EvEnd, CharNul);
          d.mode = ModeIdle;
        end else begin
          d.lst  = push(d.lst, EvChar, chr);
          d.mode = ModeWord;
        end
      end
      ModeSq: begin
        if (chr == CharNul) d = open_quote_end(d);
        else if (chr == CharSq) d.mode = ModeWord;
        else d.lst = push(d.lst, EvChar, chr);
      end
      ModeDq: begin
        if (chr == CharNul) d = open_quote_end(d);
        else if (chr == CharDq) d.mode = ModeWord;
        else if (chr == CharBsl) d.mode = ModeDqesc;
        else d.lst = push(d.lst, EvChar, chr);
      end
      ModeDqesc: begin
        if (chr == CharNul) begin
          d.lst = push(d.lst, EvChar, CharBsl);
          d = open_quote_end(d);
        end else begin
          d.lst  = push(d.lst, EvChar, chr);
          d.mode = ModeDq;
        end
      end
      ModeGt: begin
        if (chr == CharGt) begin
          d.lst  = push(d.lst, EvRapp, CharNul);
          d.mode = ModeIdle;
        end else begin
          d.lst = push(d.lst, EvRout, CharNul);
          d = plain_byte(d, chr, 1'b0);
        end
      end
      default: begin
        d = plain_byte(d, chr, 1'b0);
      end
    endcase
    dec = d;
  end

endmodule

FILE: src/sct_event_queue.sv
module sct_event_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  sct_pkg::ev_list_t         load_list,
  output logic                      can_load,
  output logic                      event_valid,
  input  logic                      event_ready,
  output logic [sct_pkg::KindW-1:0] event_kind,
  output logic [sct_pkg::CharW-1:0] word_char,
  output logic                      last_event
);
  import sct_pkg::*;

  ev_list_t        lst;
  logic [IdxW-1:0] idx;
  logic            full;
  logic            deliver;
  logic            at_last;

  assign deliver  = full && event_ready;
  assign at_last  = ({1'b0, idx} == (lst.count - CntW'(1)));
  assign can_load = !full || (deliver && at_last);

  assign event_valid = full;
  assign event_kind  = lst.ev[idx].kind;
  assign word_char   = lst.ev[idx].chr;
  assign last_event  = at_last;

  // Hold control state: fill on load, advance on each delivered transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= (load_list.count != '0);
      idx  <= '0;
    end else if (deliver) begin
      if (at_last) full <= 1'b0;
      else idx <= idx + IdxW'(1);
    end
  end

  // Capture the event list
  always_ff @(posedge clk) begin
    if (load) lst <= load_list;
  end

endmodule

FILE: src/shell_command_tokenizer.sv
// Streaming shell command-line lexer. Each char_in transaction carries one byte of a
// command line (0 ends the line) and yields zero to four event transactions: word
// characters, word end, pipe, redirect out/append/in, end of line and an unclosed-quote
// error, with last_event marking the final event of a byte. A byte is registered, decoded
// against the lexer mode combinationally, and its events leave one per cycle from an output
// list register while event_ready is high, so a byte with one event sustains one byte per
// cycle; a byte with none (an opening quote, a first '>') yields no event transaction. A
// byte passes through the input register and then the output list register.
module shell_command_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_in,
  output logic       event_valid,
  input  logic       event_ready,
  output logic [2:0] event_kind,
  output logic [7:0] word_char,
  output logic       last_event
);
  import sct_pkg::*;

  logic             byte_valid;
  logic [CharW-1:0] byte_r;
  logic [ModeW-1:0] mode;
  dec_t             dec;
  logic             can_load;
  logic             take;

  assign take       = byte_valid && can_load;
  assign char_ready = !byte_valid || can_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (char_ready) begin
      byte_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) byte_r <= char_in;
  end

  // Advance lexer mode when a byte is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeIdle;
    end else if (take) begin
      mode <= dec.mode;
    end
  end

  sct_decode u_decode (
    .mode (mode),
    .chr  (byte_r),
    .dec  (dec)
  );

  sct_event_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .load        (take),
    .load_list   (dec.lst),
    .can_load    (can_load),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_kind  (event_kind),
    .word_char   (word_char),
    .last_event  (last_event)
  );

endmodule

FILE: src/sct_checker.sv
module sct_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_ready,
  input logic [7:0] char_in,
  input logic       event_valid,
  input logic       event_ready,
  input logic [2:0] event_kind,
  input logic [7:0] word_char,
  input logic       last_event
);
  import sct_pkg::*;

  // Stalled byte transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(char_in))
    else $error("byte payload changed under stall");

  // Stalled event transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(event_kind) &&
      $stable(word_char) && $stable(last_event))
    else $error("event payload changed under stall");

  // Only word characters carry a byte
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind != EvChar) |-> (word_char == CharNul))
    else $error("word_char set on non-character event");

  // End of line closes the byte's events
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == EvEnd) |-> last_event)
    else $error("end of line not last event");

  // Unclosed quote is followed by word end
  a_uncl_next: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_ready && (event_kind == EvUncl) |=>
      !last_event && event_valid && (event_kind == EvWend))
    else $error("unclosed quote not followed by word end");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
  .clk         (clk),
  .rst         (rst),
  .char_valid  (char_valid),
  .char_ready  (char_ready),
  .char_in     (char_in),
  .event_valid (event_valid),
  .event_ready (event_ready),
  .event_kind  (event_kind),
  .word_char   (word_char),
  .last_event  (last_event)
);

FILE: dv/tb_shell_command_tokenizer.sv
module tb_shell_command_tokenizer;
  import sct_pkg::*;

  localparam int StallLimit   = 1000;
  localparam int PhaseBytes   = 40;
  localparam int DrainCycles  = 10;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] chr;
    logic             last;
  } token_event_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             char_valid  = 1'b0;
  logic             char_ready;
  logic [CharW-1:0] char_in     = CharNul;
  logic             event_valid;
  logic             event_ready = 1'b0;
  logic [KindW-1:0] event_kind;
  logic [CharW-1:0] word_char;
  logic             last_event;

  // Bytes waiting to be driven and token events waiting to be seen
  logic [CharW-1:0] pending_bytes[$];
  token_event_t     expected_events[$];
  token_event_t     byte_events[$];

  logic [ModeW-1:0] lex_state   = ModeIdle;
  logic             byte_loaded = 1'b0;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               fail_count     = 0;
  int               bytes_queued   = 0;
  int               quiet_cycles   = 0;

  shell_command_tokenizer DUT (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_in     (char_in),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_kind  (event_kind),
    .word_char   (word_char),
    .last_event  (last_event)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // Lexer predictor
  function automatic logic is_blank(input logic [CharW-1:0] c);
    return c == CharSpace || (c >= CharHtab && c <= CharCr);
  endfunction

  task automatic add_event(input logic [KindW-1:0] kind, input logic [CharW-1:0] ch);
    token_event_t ev;
    ev.kind = kind;
    ev.chr  = (kind == EvChar) ? ch : CharNul;
    ev.last = 1'b0;
    byte_events.push_back(ev);
  endtask

  task automatic lex_plain(input logic [CharW-1:0] c, input logic in_word);
    if (c == CharNul || is_blank(c) || c == CharPipe || c == CharGt || c == CharLt) begin
      if (in_word) add_event(EvWend, CharNul);
      lex_state = ModeIdle;
      if (c == CharNul) add_event(EvEnd, CharNul);
      else if (c == CharPipe) add_event(EvPipe, CharNul);
      else if (c == CharLt) add_event(EvRin, CharNul);
      else if (c == CharGt) lex_state = ModeGt;
    end else if (c == CharSq) begin
      lex_state = ModeSq;
    end else if (c == CharDq) begin
      lex_state = ModeDq;
    end else if (c == CharBsl) begin
      lex_state = ModeWesc;
    end else begin
      add_event(EvChar, c);
      lex_state = ModeWord;
    end
  endtask

  task automatic close_open_quote();
    add_event(EvUncl, CharNul);
    add_event(EvWend, CharNul);
    add_event(EvEnd, CharNul);
    lex_state = ModeIdle;
  endtask

  task automatic tokenize_byte(input logic [CharW-1:0] c);
    byte_events.delete();
    case (lex_state)
      ModeWord: lex_plain(c, 1'b1);
      ModeWesc: begin
        if (c == CharNul) begin
          add_event(EvChar, CharBsl);
          add_event(EvWend, CharNul);
          add_event(EvEnd, CharNul);
          lex_state = ModeIdle;
        end else begin
          add_event(EvChar, c);
          lex_state = ModeWord;
        end
      end
      ModeSq: begin
        if (c == CharNul) close_open_quote();
        else if (c == CharSq) lex_state = ModeWord;
        else add_event(EvChar, c);
      end
      ModeDq: begin
        if (c == CharNul) close_open_quote();
        else if (c == CharDq) lex_state = ModeWord;
        else if (c == CharBsl) lex_state = ModeDqesc;
        else add_event(EvChar, c);
      end
      ModeDqesc: begin
        if (c == CharNul) begin
          add_event(EvChar, CharBsl);
          close_open_quote();
        end else begin
          add_event(EvChar, c);
          lex_state = ModeDq;
        end
      end
      ModeGt: begin
        if (c == CharGt) begin
          add_event(EvRapp, CharNul);
          lex_state = ModeIdle;
        end else begin
          add_event(EvRout, CharNul);
          lex_plain(c, 1'b0);
        end
      end
      default: lex_plain(c, 1'b0);
    endcase
    if (byte_events.size() != 0) byte_events[$].last = 1'b1;
    foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
  endtask

  // Stimulus helpers
  task automatic push_byte(input logic [CharW-1:0] c);
    pending_bytes.push_back(c);
    bytes_queued++;
  endtask

  function automatic logic is_special(input logic [CharW-1:0] c);
    return c == CharNul || is_blank(c) || c == CharPipe || c == CharGt || c == CharLt ||
           c == CharSq || c == CharDq || c == CharBsl;
  endfunction

  function automatic logic [CharW-1:0] word_byte();
    logic [CharW-1:0] c;
    if ($urandom_range(0, 99) < 60) return CharW'($urandom_range(8'h61, 8'h7A));
    do c = CharW'($urandom_range(1, 255)); while (is_special(c));
    return c;
  endfunction

  // Nonzero byte that is neither stop byte
  function automatic logic [CharW-1:0] quoted_byte(input logic [CharW-1:0] a,
                                                   input logic [CharW-1:0] b);
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(1, 255)); while (c == a || c == b);
    return c;
  endfunction

  // Pick one of the blanks: tab through carriage return, or space
  function automatic logic [CharW-1:0] blank_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CharSpace : CharW'(CharHtab + r);
  endfunction

  // Queue one command line: tokens with random content, then a line end
  task automatic queue_line();
    int n_tok;
    int r;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 99) < 20) begin
            push_byte(CharBsl);
            push_byte(CharW'($urandom_range(1, 255)));
          end else begin
            push_byte(word_byte());
          end
        end
      end else if (r < 50) begin
        push_byte(CharSq);
        repeat ($urandom_range(0, 4)) push_byte(quoted_byte(CharSq, CharSq));
        push_byte(CharSq);
      end else if (r < 65) begin
        push_byte(CharDq);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 99) < 25) begin
            push_byte(CharBsl);
            push_byte(CharW'($urandom_range(1, 255)));
          end else begin
            push_byte(quoted_byte(CharDq, CharBsl));
          end
        end
        push_byte(CharDq);
      end else if (r < 75) begin
        case ($urandom_range(0, 3))
          0: push_byte(CharPipe);
          1: push_byte(CharLt);
          2: push_byte(CharGt);
          default: begin
            push_byte(CharGt);
            push_byte(CharGt);
          end
        endcase
      end else if (r < 88) begin
        repeat ($urandom_range(1, 2)) push_byte(blank_byte());
      end else begin
        push_byte(CharW'($urandom_range(1, 255)));
      end
    end
    // Leave a quote or an escape open at the line end now and then
    r = $urandom_range(0, 99);
    if (r < 5) begin
      push_byte(CharSq);
      push_byte(word_byte());
    end else if (r < 10) begin
      push_byte(CharDq);
      if ($urandom_range(0, 1)) push_byte(CharBsl);
    end else if (r < 14) begin
      push_byte(CharBsl);
    end else if (r < 17) begin
      push_byte(CharGt);
    end
    push_byte(CharNul);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_loaded || expected_events.size() != 0)
      @(posedge clk);
  endtask

  // Driver: load the next byte when free, hold it until the transaction completes
  always @(posedge clk) begin : drive_proc
    if (rst) begin
      char_valid  <= 1'b0;
      byte_loaded = 1'b0;
      lex_state   = ModeIdle;
    end else begin
      if (char_valid && char_ready) begin
        tokenize_byte(char_in);
        byte_loaded = 1'b0;
      end
      if (!byte_loaded && pending_bytes.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        char_in     <= pending_bytes.pop_front();
        byte_loaded = 1'b1;
      end
      char_valid <= byte_loaded;
    end
  end

  // Monitor: check each event transaction against the oldest prediction
  always @(posedge clk) begin : monitor_proc
    token_event_t want;
    if (rst) begin
      event_ready <= 1'b0;
    end else begin
      if (event_valid && event_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind=%0d char=%02h last=%b",
                                    event_kind, word_char, last_event));
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind || word_char !== want.chr ||
              last_event !== want.last)
            report_mismatch($sformatf({"got kind=%0d char=%02h last=%b, ",
                                       "want kind=%0d char=%02h last=%b"},
                                      event_kind, word_char, last_event,
                                      want.kind, want.chr, want.last));
        end
      end
      event_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((char_valid && char_ready) || (event_valid && event_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int mark;
    logic [CharW-1:0] directed[25];

    // Edge bytes, every operator, escapes and line ends in a double quote, after a backslash, after '>' and idle
    directed = '{8'h41, 8'hFF, CharHtab, CharPipe, CharGt, CharGt, CharGt, 8'h62,
                 CharLt, CharBsl, CharSpace, CharSq, CharSq, CharDq, CharBsl, CharDq,
                 CharNul, CharDq, CharBsl, CharNul, CharBsl, CharNul, CharGt, CharNul,
                 CharNul};
    foreach (directed[i]) push_byte(directed[i]);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // Random lines under each idling pattern; drain between patterns
    for (int ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        3: begin send_idle_pct = 19; recv_stall_pct = 19; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      mark = bytes_queued;
      while (bytes_queued - mark < PhaseBytes) queue_line();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
